// ----- src/ies_pkg.sv -----
package ies_pkg;

    localparam int IDX_BITS = 16;
    localparam int KEY_BITS = 2 * IDX_BITS;
    localparam logic [KEY_BITS-1:0] HASH_MUL = 32'd2654435761;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_LEVEL = 2'd1;
    localparam logic [1:0] ACT_TRI   = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_ET_FULL = 2'd1;
    localparam logic [1:0] STS_VS_FULL = 2'd2;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_TRI,
        OP_HASH,
        OP_MOD,
        OP_PROBE_NEXT,
        OP_HIT,
        OP_ET_FULL,
        OP_VS_FULL,
        OP_RD_P,
        OP_RD_Q,
        OP_MID,
        OP_SQ,
        OP_SQRT,
        OP_ZERO,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_FIN,
        OP_STORE,
        OP_EMIT_V,
        OP_EMIT_T
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_RD_P,
        ST_RD_Q,
        ST_MID,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_STORE,
        ST_EMIT_V,
        ST_EMIT_T
    } t_state;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic et_valid;
        logic et_match;
        logic probe_end;
        logic vs_full;
        logic sq_done;
        logic sqrt_done;
        logic root_zero;
        logic div_done;
        logic comp_last;
        logic edge_last;
        logic tri_last;
        logic out_free;
    } t_stat;

endpackage

// ----- src/ies_ram.sv -----
module ies_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ies_ctrl.sv -----
module ies_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_action,
    input  ies_pkg::t_stat i_stat,
    output ies_pkg::t_op   o_op,
    output logic           o_stall
);
    import ies_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid && i_action == ACT_LEVEL) n_state = ST_CLEAR;
                if (i_valid && i_action == ACT_TRI) n_state = ST_KEY;
            end
            ST_KEY:      n_state = ST_MOD;
            ST_MOD: begin
                if (i_stat.mod_done) n_state = ST_PROBE_RD;
            end
            ST_PROBE_RD: n_state = ST_PROBE_CHK;
            ST_PROBE_CHK: begin
                if (!i_stat.et_valid) begin
                    if (i_stat.vs_full) begin
                        n_state = i_stat.edge_last ? ST_EMIT_T : ST_KEY;
                    end else begin
                        n_state = ST_RD_P;
                    end
                end else if (i_stat.et_match || i_stat.probe_end) begin
                    n_state = i_stat.edge_last ? ST_EMIT_T : ST_KEY;
                end else begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_RD_P:     n_state = ST_RD_Q;
            ST_RD_Q:     n_state = ST_MID;
            ST_MID:      n_state = ST_SQ;
            ST_SQ: begin
                if (i_stat.sq_done) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (i_stat.sqrt_done) n_state = ST_DIV_INIT;
            end
            ST_DIV_INIT: n_state = i_stat.root_zero ? ST_STORE : ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_DIV_FIN;
            end
            ST_DIV_FIN:  n_state = i_stat.comp_last ? ST_STORE : ST_DIV_INIT;
            ST_STORE:    n_state = ST_EMIT_V;
            ST_EMIT_V: begin
                if (i_stat.out_free) n_state = i_stat.edge_last ? ST_EMIT_T : ST_KEY;
            end
            ST_EMIT_T: begin
                if (i_stat.out_free && i_stat.tri_last) n_state = ST_IDLE;
            end
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        case (r_state)
            ST_CLEAR: o_op = OP_CLEAR;
            ST_IDLE: begin
                if (i_valid && i_action == ACT_LOAD) o_op = OP_LOAD;
                if (i_valid && i_action == ACT_TRI) o_op = OP_TRI;
            end
            ST_KEY:   o_op = OP_HASH;
            ST_MOD:   o_op = OP_MOD;
            ST_PROBE_CHK: begin
                if (!i_stat.et_valid) begin
                    if (i_stat.vs_full) o_op = OP_VS_FULL;
                end else if (i_stat.et_match) begin
                    o_op = OP_HIT;
                end else if (i_stat.probe_end) begin
                    o_op = OP_ET_FULL;
                end else begin
                    o_op = OP_PROBE_NEXT;
                end
            end
            ST_RD_P:     o_op = OP_RD_P;
            ST_RD_Q:     o_op = OP_RD_Q;
            ST_MID:      o_op = OP_MID;
            ST_SQ:       o_op = OP_SQ;
            ST_SQRT:     o_op = OP_SQRT;
            ST_DIV_INIT: o_op = i_stat.root_zero ? OP_ZERO : OP_DIV_INIT;
            ST_DIV:      o_op = OP_DIV;
            ST_DIV_FIN:  o_op = OP_DIV_FIN;
            ST_STORE:    o_op = OP_STORE;
            ST_EMIT_V: begin
                if (i_stat.out_free) o_op = OP_EMIT_V;
            end
            ST_EMIT_T: begin
                if (i_stat.out_free) o_op = OP_EMIT_T;
            end
            default:     o_op = OP_NONE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ----- src/ies_dp.sv -----
module ies_dp #(
    parameter int VERTEX_DEPTH     = 4096,
    parameter int EDGE_TABLE_DEPTH = 8192,
    parameter int COORD_BITS       = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ies_pkg::t_op                    i_op,
    input  logic [ies_pkg::IDX_BITS-1:0]    i_vertex_slot,
    input  logic signed [COORD_BITS-1:0]    i_load_x,
    input  logic signed [COORD_BITS-1:0]    i_load_y,
    input  logic signed [COORD_BITS-1:0]    i_load_z,
    input  logic [ies_pkg::IDX_BITS-1:0]    i_index_a,
    input  logic [ies_pkg::IDX_BITS-1:0]    i_index_b,
    input  logic [ies_pkg::IDX_BITS-1:0]    i_index_c,
    input  logic                            i_stall,
    output ies_pkg::t_stat                  o_stat,
    output logic                            o_valid,
    output logic                            o_kind,
    output logic [ies_pkg::IDX_BITS-1:0]    o_new_index,
    output logic signed [COORD_BITS-1:0]    o_out_x,
    output logic signed [COORD_BITS-1:0]    o_out_y,
    output logic signed [COORD_BITS-1:0]    o_out_z,
    output logic [ies_pkg::IDX_BITS-1:0]    o_corner_one,
    output logic [ies_pkg::IDX_BITS-1:0]    o_corner_two,
    output logic [ies_pkg::IDX_BITS-1:0]    o_corner_three,
    output logic [1:0]                      o_status,
    output logic                            o_last
);
    import ies_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int IB  = IDX_BITS;
    localparam int KW  = KEY_BITS;
    localparam int SLW = IB + 1;
    localparam int VA  = $clog2(VERTEX_DEPTH);
    localparam int NW  = $clog2(VERTEX_DEPTH + 1);
    localparam int EA  = $clog2(EDGE_TABLE_DEPTH);
    localparam int MW  = EA + 1;
    localparam int MCW = 2;
    localparam int SW  = C + 3;
    localparam int CW  = $clog2(2 * C);
    localparam int VW  = 3 * C;
    localparam int EW  = 1 + KW + IB;
    localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / EDGE_TABLE_DEPTH);

    logic [IB-1:0] r_a, r_b, r_c;
    logic [1:0]    r_edge;
    logic [1:0]    r_tri;
    logic [IB-1:0] r_mid [3];
    logic [1:0]    r_err [3];
    logic [IB-1:0] i0, i1;
    logic [KW-1:0] key;
    logic [KW-1:0] r_key;
    logic [KW-1:0] r_hash;
    logic [2*KW-1:0] hash_prod;
    logic [2*KW-1:0] recip_prod;
    logic [KW-1:0]  r_hq, hq_prod, mod_sub;
    logic [MW-1:0]  r_mrem, mrem_nx;
    logic [MCW-1:0] r_mcnt;
    logic [EA-1:0]  r_pos;
    logic [EA-1:0]  r_probes;
    logic [EA-1:0]  r_clr;
    logic [NW-1:0]  r_next;

    logic          et_we;
    logic [EA-1:0] et_waddr;
    logic [EW-1:0] et_wdata;
    logic [EW-1:0] et_rd;

    logic          vs_we;
    logic [VA-1:0] vs_waddr;
    logic [VW-1:0] vs_wdata;
    logic [VA-1:0] vs_raddr;
    logic [VW-1:0] vs_rd;

    logic           slot_ok;
    logic [SLW-1:0] slot_inc;
    logic           r_p_oor, r_q_oor;
    logic [VW-1:0]  r_p;
    logic [VW-1:0]  qv;
    logic signed [C-1:0] r_m [3];
    logic signed [C-1:0] r_o [3];
    logic [1:0]     r_k;
    logic signed [C-1:0] m_sel;
    logic           m_neg;
    logic [C-1:0]   m_abs;
    logic [2*C-1:0] sq;
    logic [2*C-1:0] r_len;
    logic [SW-1:0]  r_srem, srem_sh, trial;
    logic           s_ge;
    logic [C-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic [2*C-1:0] r_num;
    logic [C-1:0]   r_drem;
    logic [C:0]     drem_sh;
    logic           d_ge;
    logic [C-1:0]   r_quo;
    logic [1:0]     tri_sts;

    logic                 r_ov;
    logic                 r_kind;
    logic [IB-1:0]        r_new_index;
    logic signed [C-1:0]  r_ox, r_oy, r_oz;
    logic [IB-1:0]        r_c1, r_c2, r_c3;
    logic [1:0]           r_status;
    logic                 r_last;
    logic                 out_free;

    always_comb begin
        case (r_edge)
            2'd0: begin
                i0 = r_a;
                i1 = r_b;
            end
            2'd1: begin
                i0 = r_b;
                i1 = r_c;
            end
            default: begin
                i0 = r_c;
                i1 = r_a;
            end
        endcase
    end

    // unordered edge key
    assign key       = (i0 < i1) ? {i0, i1} : {i1, i0};
    assign hash_prod = key * HASH_MUL;

    // remainder by reciprocal multiply, then one correction step
    assign recip_prod = r_hash * RECIP;
    assign hq_prod    = r_hq * KW'(EDGE_TABLE_DEPTH);
    assign mod_sub    = r_hash - hq_prod;
    assign mrem_nx    = (r_mrem >= MW'(EDGE_TABLE_DEPTH)) ?
                        r_mrem - MW'(EDGE_TABLE_DEPTH) : r_mrem;

    assign slot_ok  = ({1'b0, i_vertex_slot} < SLW'(VERTEX_DEPTH));
    assign slot_inc = {1'b0, i_vertex_slot} + SLW'(1);

    assign qv    = r_q_oor ? '0 : vs_rd;
    assign m_sel = r_m[r_k];
    assign m_neg = m_sel[C-1];
    assign m_abs = m_neg ? (~m_sel + 1'b1) : m_sel;
    assign sq    = m_abs * m_abs;

    assign srem_sh = {r_srem[SW-3:0], r_len[2*C-1:2*C-2]};
    assign trial   = SW'({r_root, 2'b01});
    assign s_ge    = (srem_sh >= trial);

    assign drem_sh = {r_drem, r_num[2*C-1]};
    assign d_ge    = (drem_sh >= {1'b0, r_root});

    assign tri_sts = (r_err[0] != STS_OK) ? r_err[0] :
                     ((r_err[1] != STS_OK) ? r_err[1] : r_err[2]);

    assign out_free = !r_ov || !i_stall;

    // memories
    always_comb begin
        et_we    = (i_op == OP_CLEAR) || (i_op == OP_STORE);
        et_waddr = (i_op == OP_CLEAR) ? r_clr : r_pos;
        et_wdata = (i_op == OP_CLEAR) ? '0 : {1'b1, r_key, IB'(r_next)};
        vs_we    = ((i_op == OP_LOAD) && slot_ok) || (i_op == OP_STORE);
        vs_waddr = (i_op == OP_STORE) ? r_next[VA-1:0] : i_vertex_slot[VA-1:0];
        vs_wdata = (i_op == OP_STORE) ? {r_o[2], r_o[1], r_o[0]}
                                      : {i_load_z, i_load_y, i_load_x};
        vs_raddr = (i_op == OP_RD_Q) ? i1[VA-1:0] : i0[VA-1:0];
    end

    ies_ram #(.WIDTH(EW), .DEPTH(EDGE_TABLE_DEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (et_we),
        .i_waddr (et_waddr),
        .i_wdata (et_wdata),
        .i_raddr (r_pos),
        .o_rdata (et_rd)
    );

    ies_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (vs_waddr),
        .i_wdata (vs_wdata),
        .i_raddr (vs_raddr),
        .o_rdata (vs_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_next <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_op == OP_CLEAR) begin
                r_clr <= o_stat.clr_done ? '0 : r_clr + 1'b1;
            end
            if (i_op == OP_LOAD && slot_ok && slot_inc > SLW'(r_next)) begin
                r_next <= NW'(slot_inc);
            end
            if (i_op == OP_STORE) begin
                r_next <= r_next + 1'b1;
            end
            if (i_op == OP_EMIT_V || i_op == OP_EMIT_T) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_TRI: begin
                r_a    <= i_index_a;
                r_b    <= i_index_b;
                r_c    <= i_index_c;
                r_edge <= 2'd0;
                r_tri  <= 2'd0;
            end
            OP_HASH: begin
                r_key    <= key;
                r_hash   <= hash_prod[KW-1:0];
                r_mrem   <= '0;
                r_mcnt   <= '0;
                r_probes <= '0;
            end
            OP_MOD: begin
                r_hq   <= recip_prod[2*KW-1:KW];
                r_mrem <= MW'(mod_sub);
                r_mcnt <= r_mcnt + 1'b1;
                if (o_stat.mod_done) r_pos <= EA'(mrem_nx);
            end
            OP_PROBE_NEXT: begin
                r_pos    <= (r_pos == EA'(EDGE_TABLE_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                r_probes <= r_probes + 1'b1;
            end
            OP_HIT: begin
                r_mid[r_edge] <= et_rd[IB-1:0];
                r_err[r_edge] <= STS_OK;
                r_edge        <= r_edge + 1'b1;
            end
            OP_ET_FULL: begin
                r_mid[r_edge] <= i0;
                r_err[r_edge] <= STS_ET_FULL;
                r_edge        <= r_edge + 1'b1;
            end
            OP_VS_FULL: begin
                r_mid[r_edge] <= i0;
                r_err[r_edge] <= STS_VS_FULL;
                r_edge        <= r_edge + 1'b1;
            end
            OP_RD_P: begin
                r_p_oor <= !({1'b0, i0} < SLW'(VERTEX_DEPTH));
            end
            OP_RD_Q: begin
                r_p     <= r_p_oor ? '0 : vs_rd;
                r_q_oor <= !({1'b0, i1} < SLW'(VERTEX_DEPTH));
            end
            OP_MID: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k] <= C'(({r_p[k*C+C-1], r_p[k*C +: C]}
                                + {qv[k*C+C-1], qv[k*C +: C]}) >>> 1);
                end
                r_len  <= '0;
                r_k    <= 2'd0;
                r_cnt  <= '0;
                r_srem <= '0;
                r_root <= '0;
            end
            OP_SQ: begin
                r_len <= r_len + sq;
                r_k   <= o_stat.sq_done ? 2'd0 : r_k + 1'b1;
            end
            OP_SQRT: begin
                r_srem <= s_ge ? srem_sh - trial : srem_sh;
                r_root <= {r_root[C-2:0], s_ge};
                r_len  <= r_len << 2;
                r_cnt  <= r_cnt + 1'b1;
            end
            OP_ZERO: begin
                for (int k = 0; k < 3; k++) begin
                    r_o[k] <= '0;
                end
            end
            OP_DIV_INIT: begin
                // rounded quotient: add half the divisor
                r_num  <= (2*C)'({m_abs, {(C-2){1'b0}}}) + (2*C)'(r_root >> 1);
                r_drem <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            OP_DIV: begin
                r_drem <= C'(d_ge ? drem_sh - {1'b0, r_root} : drem_sh);
                r_quo  <= {r_quo[C-2:0], d_ge};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt + 1'b1;
            end
            OP_DIV_FIN: begin
                r_o[r_k] <= m_neg ? (~r_quo + 1'b1) : r_quo;
                r_k      <= r_k + 1'b1;
            end
            OP_STORE: begin
                r_mid[r_edge] <= IB'(r_next);
                r_err[r_edge] <= STS_OK;
            end
            OP_EMIT_V: begin
                r_kind      <= KIND_VERTEX;
                r_new_index <= r_mid[r_edge];
                r_ox        <= r_o[0];
                r_oy        <= r_o[1];
                r_oz        <= r_o[2];
                r_c1        <= '0;
                r_c2        <= '0;
                r_c3        <= '0;
                r_status    <= STS_OK;
                r_last      <= 1'b0;
                r_edge      <= r_edge + 1'b1;
            end
            OP_EMIT_T: begin
                r_kind      <= KIND_TRI;
                r_new_index <= '0;
                r_ox        <= '0;
                r_oy        <= '0;
                r_oz        <= '0;
                r_status    <= tri_sts;
                r_last      <= (r_tri == 2'd3);
                r_tri       <= r_tri + 1'b1;
                case (r_tri)
                    2'd0: begin
                        r_c1 <= r_a;
                        r_c2 <= r_mid[0];
                        r_c3 <= r_mid[2];
                    end
                    2'd1: begin
                        r_c1 <= r_mid[0];
                        r_c2 <= r_b;
                        r_c3 <= r_mid[1];
                    end
                    2'd2: begin
                        r_c1 <= r_mid[1];
                        r_c2 <= r_c;
                        r_c3 <= r_mid[2];
                    end
                    default: begin
                        r_c1 <= r_mid[0];
                        r_c2 <= r_mid[1];
                        r_c3 <= r_mid[2];
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.clr_done  = (r_clr == EA'(EDGE_TABLE_DEPTH - 1));
        o_stat.mod_done  = (r_mcnt == MCW'(2));
        o_stat.et_valid  = et_rd[EW-1];
        o_stat.et_match  = (et_rd[EW-2:IB] == r_key);
        o_stat.probe_end = (r_probes == EA'(EDGE_TABLE_DEPTH - 1));
        o_stat.vs_full   = (r_next == NW'(VERTEX_DEPTH));
        o_stat.sq_done   = (r_k == 2'd2);
        o_stat.sqrt_done = (r_cnt == CW'(C - 1));
        o_stat.root_zero = (r_root == '0);
        o_stat.div_done  = (r_cnt == CW'(2 * C - 1));
        o_stat.comp_last = (r_k == 2'd2);
        o_stat.edge_last = (r_edge == 2'd2);
        o_stat.tri_last  = (r_tri == 2'd3);
        o_stat.out_free  = out_free;
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_new_index    = r_new_index;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_corner_one   = r_c1;
    assign o_corner_two   = r_c2;
    assign o_corner_three = r_c3;
    assign o_status       = r_status;
    assign o_last         = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |-> !(i_op == OP_EMIT_V || i_op == OP_EMIT_T))
        else $error("result register overwritten while stalled");

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= NW'(VERTEX_DEPTH))
        else $error("next free vertex beyond store");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_STORE) |-> !o_stat.vs_full)
        else $error("vertex stored into full store");

    a_last_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT_T && r_tri == 2'd3) |=> (o_valid && o_last))
        else $error("fourth child triangle not marked last");

endmodule

// ----- src/icosphere_edge_subdivider.sv -----
// One level of icosphere midpoint subdivision. A load item writes one vertex when its
// slot lies inside the vertex store; a level start clears the edge table in one pass,
// and the same pass runs after reset, during which no item is taken. A triangle item
// is accepted and then, per edge, runs the key multiply and the hash remainder, then
// edge table probes; an edge that misses, with room in the vertex store, adds vertex
// reads and midpoint, squaring, the bit-serial square root and (for a nonzero root)
// the serial divider for normalization, plus a store and an emit. The four child
// triangles then follow in turn; a stalled result holds the sequence. The serial
// divider and square root dominate the time of a triangle with new midpoints.
module icosphere_edge_subdivider #(
    parameter int VERTEX_DEPTH     = 4096,
    parameter int EDGE_TABLE_DEPTH = 8192,
    parameter int COORD_BITS       = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [ies_pkg::IDX_BITS-1:0]  i_vertex_slot,
    input  logic signed [COORD_BITS-1:0]  i_load_x,
    input  logic signed [COORD_BITS-1:0]  i_load_y,
    input  logic signed [COORD_BITS-1:0]  i_load_z,
    input  logic [ies_pkg::IDX_BITS-1:0]  i_index_a,
    input  logic [ies_pkg::IDX_BITS-1:0]  i_index_b,
    input  logic [ies_pkg::IDX_BITS-1:0]  i_index_c,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [ies_pkg::IDX_BITS-1:0]  o_new_index,
    output logic signed [COORD_BITS-1:0]  o_out_x,
    output logic signed [COORD_BITS-1:0]  o_out_y,
    output logic signed [COORD_BITS-1:0]  o_out_z,
    output logic [ies_pkg::IDX_BITS-1:0]  o_corner_one,
    output logic [ies_pkg::IDX_BITS-1:0]  o_corner_two,
    output logic [ies_pkg::IDX_BITS-1:0]  o_corner_three,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import ies_pkg::*;

    t_op   op;
    t_stat stat;

    ies_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_stat   (stat),
        .o_op     (op),
        .o_stall  (o_stall)
    );

    ies_dp #(
        .VERTEX_DEPTH     (VERTEX_DEPTH),
        .EDGE_TABLE_DEPTH (EDGE_TABLE_DEPTH),
        .COORD_BITS       (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_vertex_slot  (i_vertex_slot),
        .i_load_x       (i_load_x),
        .i_load_y       (i_load_y),
        .i_load_z       (i_load_z),
        .i_index_a      (i_index_a),
        .i_index_b      (i_index_b),
        .i_index_c      (i_index_c),
        .i_stall        (i_stall),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_new_index    (o_new_index),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_corner_one   (o_corner_one),
        .o_corner_two   (o_corner_two),
        .o_corner_three (o_corner_three),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule
